// ===== hw/rtl/swme_pkg.sv =====
// Shared types, codes and field widths of the sorted word match engine.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package swme_pkg;

  // Defaults for the top-level parameters
  localparam int MAX_DOCS_DEF          = 256;
  localparam int MAX_WORDS_PER_DOC_DEF = 1024;
  localparam int STORE_DEPTH_DEF       = 16384;
  localparam int WORD_BITS_DEF         = 20;

  // Fixed field widths
  localparam int DOC_INDEX_W = 8;
  localparam int WORD_IN_W   = 20;
  localparam int COORD_W     = 32;
  localparam int SLOT_W      = 8;
  localparam int TOTAL_W     = 11;

  localparam int IN_TDATA_W  = 96;
  localparam int OUT_TDATA_W = 152;

  localparam logic [TOTAL_W-1:0] MATCH_SAT = 11'd2047;

  // Request kinds on tuser
  localparam logic OP_INSERT   = 1'b0;
  localparam logic OP_QUERY    = 1'b1;
  localparam logic KIND_INSERT = 1'b0;
  localparam logic KIND_QUERY  = 1'b1;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_OVERFLOW = 2'd2
  } status_t;

  // Controller to datapath
  typedef struct packed {
    logic load_item;
    logic do_insert;
    logic doc_lookup;
    logic scan_init;
    logic store_read;
    logic compare;
    logic emit;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic item_last;
    logic doc_valid;
    logic cursor_lt_end;
    logic word_less;
    logic hit;
    logic out_free;
  } stat_t;

endpackage

`default_nettype wire

// ===== hw/rtl/sorted_word_match_engine.sv =====
// Top level of the sorted word match engine: stream ports, controller and
// datapath. Depends on swme_pkg, swme_ctrl and swme_datapath.
`default_nettype none

// The engine keeps a forward file of documents, each a run of ascending
// visual words with raw x/y coordinate patterns, and matches query word
// lists against one stored document at a time. Requests are taken one at a
// time. An insert request is accepted, then the update runs; when it is
// the last of a document its status also goes to the output. A query
// request reads the document table, sets up the cursor and then steps
// through stored words: each stored word costs one registered read of the
// word store plus one compare, all through the single read port of that
// store. Over a whole sorted query list the cursor never moves back, and
// passes each stored word of the document at most once. A result that
// waits in the output register stalls the next request that has a result
// to give, and so every request behind that one. The stores need no
// clearing after reset: a query naming a slot not yet committed matches
// nothing.
module sorted_word_match_engine
  import swme_pkg::*;
#(
  parameter int MAX_DOCS          = MAX_DOCS_DEF,
  parameter int MAX_WORDS_PER_DOC = MAX_WORDS_PER_DOC_DEF,
  parameter int STORE_DEPTH       = STORE_DEPTH_DEF,
  parameter int WORD_BITS         = WORD_BITS_DEF
) (
  input  wire                    clk,
  input  wire                    rst,
  input  wire                    s_axis_tvalid,
  output logic                   s_axis_tready,
  // doc_index[7:0], word[27:8], x_bits[59:28], y_bits[91:60], zero pad
  input  wire [IN_TDATA_W-1:0]   s_axis_tdata,
  // op
  input  wire                    s_axis_tuser,
  input  wire                    s_axis_tlast,
  output logic                   m_axis_tvalid,
  input  wire                    m_axis_tready,
  // status[1:0], doc_slot[9:2], match_valid[10], db_x[42:11], db_y[74:43],
  // query_x[106:75], query_y[138:107], match_total[149:139], zero pad
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,
  // kind
  output logic                   m_axis_tuser,
  output logic                   m_axis_tlast
);

  cmd_t  cmd;
  stat_t stat;

  // Sequencer: decides which datapath step runs each cycle
  swme_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_op    (s_axis_tuser),
    .in_ready (s_axis_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // Stores, cursor and output register
  swme_datapath #(
    .MAX_DOCS          (MAX_DOCS),
    .MAX_WORDS_PER_DOC (MAX_WORDS_PER_DOC),
    .STORE_DEPTH       (STORE_DEPTH),
    .WORD_BITS         (WORD_BITS)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .in_tdata   (s_axis_tdata),
    .in_tuser   (s_axis_tuser),
    .in_tlast   (s_axis_tlast),
    .cmd        (cmd),
    .stat       (stat),
    .out_tvalid (m_axis_tvalid),
    .out_tready (m_axis_tready),
    .out_tdata  (m_axis_tdata),
    .out_tuser  (m_axis_tuser),
    .out_tlast  (m_axis_tlast)
  );

`ifndef ASSERT_OFF
  // One request at a time: an accepted request blocks the next cycle
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("request accepted while previous one still in work");

  // Insert results never carry done or a match count
  a_insert_clean: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tuser == KIND_INSERT) |->
      (!m_axis_tlast && m_axis_tdata[149:139] == '0))
    else $error("insert result carries query fields");

  // A failed commit reports slot zero
  a_failed_slot: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tuser == KIND_INSERT && m_axis_tdata[1:0] != ST_OK) |->
      (m_axis_tdata[9:2] == '0))
    else $error("failed commit reports a slot");

  // A query result without a match is only produced for the last item
  a_nomatch_last: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tuser == KIND_QUERY && !m_axis_tdata[10]) |->
      m_axis_tlast)
    else $error("unmatched query result before the last item");
`endif

endmodule

`default_nettype wire

// ===== hw/rtl/swme_ctrl.sv =====
// Sequencing state machine of the sorted word match engine.
// Depends on swme_pkg for the command and status structs.
`default_nettype none

module swme_ctrl
  import swme_pkg::*;
(
  input  wire   clk,
  input  wire   rst,
  input  wire   in_valid,
  input  wire   in_op,
  output logic  in_ready,
  input  stat_t stat,
  output cmd_t  cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_INSERT,
    S_LOOKUP,
    S_INIT,
    S_READ,
    S_COMPARE,
    S_FINISH
  } state_t;

  state_t state;
  logic   need_result;

  assign in_ready    = (state == S_IDLE);
  assign need_result = stat.item_last || stat.hit;

  always_comb begin
    cmd            = '0;
    cmd.load_item  = (state == S_IDLE) && in_valid;
    cmd.do_insert  = (state == S_INSERT);
    cmd.doc_lookup = (state == S_LOOKUP);
    cmd.scan_init  = (state == S_INIT);
    cmd.store_read = (state == S_READ) && stat.cursor_lt_end;
    cmd.compare    = (state == S_COMPARE);
    cmd.emit       = (state == S_FINISH) && need_result && stat.out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            state <= (in_op == OP_INSERT) ? S_INSERT : S_LOOKUP;
          end
        end
        S_INSERT: begin
          state <= stat.item_last ? S_FINISH : S_IDLE;
        end
        S_LOOKUP: begin
          state <= S_INIT;
        end
        S_INIT: begin
          state <= stat.doc_valid ? S_READ : S_FINISH;
        end
        S_READ: begin
          state <= stat.cursor_lt_end ? S_COMPARE : S_FINISH;
        end
        S_COMPARE: begin
          state <= stat.word_less ? S_READ : S_FINISH;
        end
        S_FINISH: begin
          if (!need_result || stat.out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/swme_datapath.sv =====
// Datapath of the sorted word match engine: word store, document table,
// insert bookkeeping, scan cursor and the output register. Uses swme_pkg.
`default_nettype none

module swme_datapath
  import swme_pkg::*;
#(
  parameter int MAX_DOCS          = MAX_DOCS_DEF,
  parameter int MAX_WORDS_PER_DOC = MAX_WORDS_PER_DOC_DEF,
  parameter int STORE_DEPTH       = STORE_DEPTH_DEF,
  parameter int WORD_BITS         = WORD_BITS_DEF
) (
  input  wire                    clk,
  input  wire                    rst,
  input  wire [IN_TDATA_W-1:0]   in_tdata,
  input  wire                    in_tuser,
  input  wire                    in_tlast,
  input  cmd_t                   cmd,
  output stat_t                  stat,
  output logic                   out_tvalid,
  input  wire                    out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,
  output logic                   out_tuser,
  output logic                   out_tlast
);

  localparam int DA  = (MAX_DOCS > 1) ? $clog2(MAX_DOCS) : 1;
  localparam int DCW = $clog2(MAX_DOCS + 1);
  localparam int SA  = $clog2(STORE_DEPTH);
  localparam int FW  = $clog2(STORE_DEPTH + 1);
  localparam int PW  = $clog2(MAX_WORDS_PER_DOC + 1);

  // Memories
  logic [WORD_BITS-1:0] word_mem [STORE_DEPTH];
  logic [COORD_W-1:0]   x_mem    [STORE_DEPTH];
  logic [COORD_W-1:0]   y_mem    [STORE_DEPTH];
  logic [SA-1:0]        start_mem[MAX_DOCS];
  logic [PW-1:0]        len_mem  [MAX_DOCS];

  // Latched request
  logic                   item_op;
  logic                   item_last;
  logic [DOC_INDEX_W-1:0] item_doc;
  logic [WORD_BITS-1:0]   item_word;
  logic [COORD_W-1:0]     item_x;
  logic [COORD_W-1:0]     item_y;

  // Insert state
  logic [FW-1:0]  fill_count;
  logic [DCW-1:0] doc_count;
  logic [PW-1:0]  pending_length;
  status_t        pending_error;
  status_t        res_status;
  logic [SLOT_W-1:0] res_slot;

  // Query state
  logic [FW-1:0]      cursor;
  logic [FW-1:0]      end_addr;
  logic [TOTAL_W-1:0] match_count;
  logic               query_active;
  logic               doc_valid;
  logic               hit;
  logic [COORD_W-1:0] hit_x;
  logic [COORD_W-1:0] hit_y;
  logic [SA-1:0]      dt_start;
  logic [PW-1:0]      dt_len;
  logic [WORD_BITS-1:0] rd_word;
  logic [COORD_W-1:0]   rd_x;
  logic [COORD_W-1:0]   rd_y;

  // Output register
  logic                out_valid;
  logic                o_kind;
  status_t             o_status;
  logic [SLOT_W-1:0]   o_slot;
  logic                o_mv;
  logic [COORD_W-1:0]  o_dbx;
  logic [COORD_W-1:0]  o_dby;
  logic [COORD_W-1:0]  o_qx;
  logic [COORD_W-1:0]  o_qy;
  logic [TOTAL_W-1:0]  o_total;
  logic                o_done;

  // Combinational helpers
  logic [31:0]    in_word_ext;
  logic [31:0]    in_doc_ext;
  logic [31:0]    item_doc_ext;
  logic [31:0]    doc_count_ext;
  logic [31:0]    wr_sum;
  logic [31:0]    end_sum;
  logic [SA-1:0]  wr_addr;
  logic [DA-1:0]  doc_idx;
  logic [DA-1:0]  slot_idx;
  logic [PW-1:0]  pend_len_inc;
  logic [FW-1:0]  fill_next;
  logic           db_full;
  logic           overflow;
  status_t        ins_err;
  status_t        err_merged;
  logic           store_we;
  logic           doc_we;

  always_comb begin
    in_word_ext   = 32'(in_tdata[27:8]);
    in_doc_ext    = 32'(in_tdata[7:0]);
    item_doc_ext  = 32'(item_doc);
    doc_count_ext = 32'(doc_count);
    doc_idx       = item_doc_ext[DA-1:0];
    slot_idx      = doc_count[DA-1:0];
    wr_sum        = 32'(fill_count) + 32'(pending_length);
    wr_addr       = wr_sum[SA-1:0];
    end_sum       = 32'(dt_start) + 32'(dt_len);
    pend_len_inc  = pending_length + PW'(1);
    fill_next     = FW'(32'(fill_count) + 32'(pend_len_inc));
    db_full       = doc_count_ext >= 32'(MAX_DOCS);
    overflow      = (32'(pending_length) >= 32'(MAX_WORDS_PER_DOC)) ||
                    (wr_sum >= 32'(STORE_DEPTH));
    if (db_full) begin
      ins_err = ST_FULL;
    end else if (overflow) begin
      ins_err = ST_OVERFLOW;
    end else begin
      ins_err = ST_OK;
    end
    err_merged = (pending_error == ST_OK) ? ins_err : pending_error;
    store_we   = cmd.do_insert && (ins_err == ST_OK);
    doc_we     = cmd.do_insert && item_last && (err_merged == ST_OK);
  end

  // Word store: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (store_we) begin
      word_mem[wr_addr] <= item_word;
      x_mem[wr_addr]    <= item_x;
      y_mem[wr_addr]    <= item_y;
    end
    if (cmd.store_read) begin
      rd_word <= word_mem[cursor[SA-1:0]];
      rd_x    <= x_mem[cursor[SA-1:0]];
      rd_y    <= y_mem[cursor[SA-1:0]];
    end
  end

  // Document table
  always_ff @(posedge clk) begin
    if (doc_we) begin
      start_mem[slot_idx] <= fill_count[SA-1:0];
      len_mem[slot_idx]   <= pend_len_inc;
    end
    if (cmd.doc_lookup) begin
      dt_start <= start_mem[doc_idx];
      dt_len   <= len_mem[doc_idx];
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      item_op   <= in_tuser;
      item_last <= in_tlast;
      item_doc  <= in_tdata[7:0];
      item_word <= in_word_ext[WORD_BITS-1:0];
      item_x    <= in_tdata[59:28];
      item_y    <= in_tdata[91:60];
      doc_valid <= in_doc_ext < doc_count_ext;
    end
    if (cmd.do_insert && item_last) begin
      res_status <= err_merged;
      res_slot   <= (err_merged == ST_OK) ? doc_count_ext[SLOT_W-1:0] : '0;
    end
    if (cmd.scan_init && doc_valid) begin
      end_addr <= end_sum[FW-1:0];
    end
    if (cmd.compare && (rd_word == item_word)) begin
      hit_x <= rd_x;
      hit_y <= rd_y;
    end
    if (cmd.emit) begin
      if (item_op == OP_INSERT) begin
        o_kind   <= KIND_INSERT;
        o_status <= res_status;
        o_slot   <= res_slot;
        o_mv     <= 1'b0;
        o_dbx    <= '0;
        o_dby    <= '0;
        o_qx     <= '0;
        o_qy     <= '0;
        o_total  <= '0;
        o_done   <= 1'b0;
      end else begin
        o_kind   <= KIND_QUERY;
        o_status <= ST_OK;
        o_slot   <= '0;
        o_mv     <= hit;
        o_dbx    <= hit ? hit_x : '0;
        o_dby    <= hit ? hit_y : '0;
        o_qx     <= hit ? item_x : '0;
        o_qy     <= hit ? item_y : '0;
        o_total  <= match_count;
        o_done   <= item_last;
      end
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      fill_count     <= '0;
      doc_count      <= '0;
      pending_length <= '0;
      pending_error  <= ST_OK;
      cursor         <= '0;
      match_count    <= '0;
      query_active   <= 1'b0;
      hit            <= 1'b0;
      out_valid      <= 1'b0;
    end else begin
      if (cmd.load_item) begin
        hit <= 1'b0;
      end
      if (cmd.do_insert) begin
        if (item_last) begin
          pending_length <= '0;
          pending_error  <= ST_OK;
          if (err_merged == ST_OK) begin
            fill_count <= fill_next;
            doc_count  <= doc_count + DCW'(1);
          end
        end else begin
          pending_error <= err_merged;
          if (ins_err == ST_OK) begin
            pending_length <= pend_len_inc;
          end
        end
      end
      if (cmd.scan_init && !query_active) begin
        query_active <= 1'b1;
        match_count  <= '0;
        cursor       <= doc_valid ? FW'(dt_start) : '0;
      end
      if (cmd.compare && (rd_word <= item_word)) begin
        // Skip a smaller stored word, or consume an equal one
        cursor <= cursor + FW'(1);
        if (rd_word == item_word) begin
          hit <= 1'b1;
          if (match_count != MATCH_SAT) begin
            match_count <= match_count + TOTAL_W'(1);
          end
        end
      end
      if (cmd.emit) begin
        out_valid <= 1'b1;
        if (item_op == OP_QUERY && item_last) begin
          query_active <= 1'b0;
          match_count  <= '0;
          cursor       <= '0;
        end
      end else if (out_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_comb begin
    stat.item_last     = item_last;
    stat.doc_valid     = doc_valid;
    stat.cursor_lt_end = cursor < end_addr;
    stat.word_less     = rd_word < item_word;
    stat.hit           = hit;
    stat.out_free      = !out_valid || out_tready;
  end

  assign out_tvalid = out_valid;
  assign out_tuser  = o_kind;
  assign out_tlast  = o_done;
  assign out_tdata  = {2'b00, o_total, o_qy, o_qx, o_dby, o_dbx, o_mv, o_slot, o_status};

endmodule

`default_nettype wire
